### hdl/lcd_pkg.sv
// Shared constants and types for the load-cell touch detector.
// Used by lcd_div and load_cell_touch_detector; depends on nothing.
package lcd_pkg;

  localparam int SAMPLE_WIDTH    = 32;
  localparam int FRACTION_BITS   = 8;
  localparam int FACTOR_WIDTH    = 9;
  localparam int NUM_WIDTH       = SAMPLE_WIDTH + FACTOR_WIDTH + 1;
  localparam int DIVISOR_WIDTH   = 16;
  localparam int IN_DATA_WIDTH   = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_FIELD_WIDTH = 2 * SAMPLE_WIDTH + 1;
  localparam int OUT_DATA_WIDTH  = ((OUT_FIELD_WIDTH + 7) / 8) * 8;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 24;

  localparam int THRESHOLD_WIDTH = 24;
  localparam int COUNT_WIDTH     = 8;
  localparam int WEIGHT_WIDTH    = 16;

  localparam logic [THRESHOLD_WIDTH-1:0] THRESHOLD_RESET =
    THRESHOLD_WIDTH'(250 << FRACTION_BITS);
  localparam logic [COUNT_WIDTH-1:0]  RUN_LIMIT_RESET = COUNT_WIDTH'(3);
  localparam logic [COUNT_WIDTH-1:0]  HORIZON_RESET   = COUNT_WIDTH'(100);
  localparam logic [COUNT_WIDTH-1:0]  HOLD_RESET      = COUNT_WIDTH'(10);
  localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_RESET    = WEIGHT_WIDTH'(50);
  localparam logic [COUNT_WIDTH-1:0]  BLINK_RESET     = COUNT_WIDTH'(10);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_THRESHOLD,
    CFG_RUN_LIMIT,
    CFG_HORIZON,
    CFG_HOLD,
    CFG_REF_WEIGHT,
    CFG_BLINK
  } cfg_index_t;

endpackage

### hdl/lcd_div.sv
// Sequential signed floor divider, one quotient bit per cycle.
// Depends on lcd_pkg for the numerator, divisor and quotient widths.
module lcd_div (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  logic signed [lcd_pkg::NUM_WIDTH-1:0]       numer,
  input  logic        [lcd_pkg::DIVISOR_WIDTH-1:0]   divisor,
  output logic                                       done,
  output logic signed [lcd_pkg::SAMPLE_WIDTH-1:0]    quot
);
  import lcd_pkg::*;

  localparam int MAG_W = NUM_WIDTH - 1;
  localparam int CNT_W = $clog2(MAG_W);
  localparam int DW    = DIVISOR_WIDTH;

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_t;

  dstate_t                     state_r;
  logic                        neg_r;
  logic [MAG_W-1:0]            mag_r;
  logic [DW-1:0]               rem_r;
  logic [DW-1:0]               dvs_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        done_r;
  logic signed [SAMPLE_WIDTH-1:0] quot_r;

  logic signed [NUM_WIDTH-1:0] numer_abs;
  logic [DW+1:0]               trial;
  logic                        ge;
  logic [DW-1:0]               rem_nxt;
  logic [MAG_W-1:0]            qfix;

  always_comb begin
    numer_abs = numer[NUM_WIDTH-1] ? -numer : numer;
    trial     = {1'b0, rem_r, mag_r[MAG_W-1]} - {2'b00, dvs_r};
    ge        = !trial[DW+1];
    rem_nxt   = ge ? trial[DW-1:0] : {rem_r[DW-2:0], mag_r[MAG_W-1]};
    qfix      = neg_r ? (~mag_r + MAG_W'(rem_r == '0)) : mag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == D_FIX);
      case (state_r)
        D_IDLE: begin
          if (start) begin
            neg_r   <= numer[NUM_WIDTH-1];
            mag_r   <= numer_abs[MAG_W-1:0];
            rem_r   <= '0;
            dvs_r   <= divisor;
            cnt_r   <= CNT_W'(MAG_W - 1);
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r <= rem_nxt;
          mag_r <= {mag_r[MAG_W-2:0], ge};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= D_FIX;
          end
        end
        D_FIX: begin
          quot_r  <= qfix[SAMPLE_WIDTH-1:0];
          state_r <= D_IDLE;
        end
        default: begin
          state_r <= D_IDLE;
        end
      endcase
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

### hdl/load_cell_touch_detector.sv
// Top level of the load-cell touch detector: sequencer, state and ports.
// Depends on lcd_pkg and on lcd_div for every average and scale division.
//
// Channel  Direction  Handshake            Payload
// in_      slave      in_tvalid/in_tready  sample in tdata, calibrate mode in tuser
// out_     master     out_tvalid/out_tready indicator, difference, scale; tuser = scale valid
// cfg_     slave      cfg_valid/cfg_ready  register index and data, always ready
//
// An item is accepted, multiplied, then added as the divider is loaded; the divider works out
// the quotient bits and fixes the sign; the quotient is taken, then the output register loads.
// Items that start calibration, or end it with a zero weight, go straight to the output stage.
// The block takes no new word until the current result is in the output register.
// Reset is synchronous and active low; it restores the sequencer, detector state and register defaults.
module load_cell_touch_detector (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // Fields from bit 0: sample.
  input  logic [lcd_pkg::IN_DATA_WIDTH-1:0]      in_tdata,
  // Fields from bit 0: calibrate_mode.
  input  logic                                   in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // Fields from bit 0: indicator_level, difference, scale_value.
  output logic [lcd_pkg::OUT_DATA_WIDTH-1:0]     out_tdata,
  // Fields from bit 0: scale_valid.
  output logic                                   out_tuser,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [lcd_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [lcd_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);
  import lcd_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int CMP_W = (SW + 1 > THRESHOLD_WIDTH + 1) ? SW + 1 : THRESHOLD_WIDTH + 1;
  localparam int PAD_W = OUT_DATA_WIDTH - OUT_FIELD_WIDTH;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ADD, S_DIV, S_OUT} state_t;
  typedef enum logic [1:0] {K_BASE, K_CAL, K_SCALE} kind_t;

  state_t state_r;
  kind_t  kind_r;

  logic [THRESHOLD_WIDTH-1:0] threshold_r;
  logic [COUNT_WIDTH-1:0]     run_limit_r;
  logic [COUNT_WIDTH-1:0]     horizon_r;
  logic [COUNT_WIDTH-1:0]     hold_len_r;
  logic [WEIGHT_WIDTH-1:0]    weight_r;
  logic [COUNT_WIDTH-1:0]     blink_per_r;

  logic                       prev_mode_r;
  logic signed [SW-1:0]       base_avg_r;
  logic signed [SW-1:0]       cal_avg_r;
  logic [COUNT_WIDTH-1:0]     pressed_r;
  logic [COUNT_WIDTH-1:0]     hold_r;
  logic [COUNT_WIDTH-1:0]     blink_r;
  logic                       ind_r;

  logic signed [SW-1:0]       mul_a_r;
  logic [FACTOR_WIDTH-1:0]    fac_r;
  logic signed [SW-1:0]       add_r;
  logic [DIVISOR_WIDTH-1:0]   dvs_r;
  logic signed [NUM_WIDTH-1:0] prod_r;
  logic signed [SW-1:0]       diff_r;
  logic signed [SW-1:0]       scale_r;
  logic                       flag_r;

  logic                       out_valid_r;
  logic                       out_ind_r;
  logic signed [SW-1:0]       out_diff_r;
  logic signed [SW-1:0]       out_scale_r;
  logic                       out_flag_r;

  logic                       in_accept;
  logic                       mode;
  logic signed [SW-1:0]       sample;
  logic [COUNT_WIDTH-1:0]     h;
  logic signed [SW:0]         d;
  logic                       above;
  logic [COUNT_WIDTH-1:0]     pressed_nxt;
  logic                       touch;
  logic [COUNT_WIDTH-1:0]     hold_tmp;
  logic [COUNT_WIDTH-1:0]     hold_nxt;
  logic                       ind_tmp;
  logic                       ind_nxt;
  logic signed [SW-1:0]       sat_d;
  logic [COUNT_WIDTH-1:0]     blink_inc;
  logic signed [NUM_WIDTH-1:0] numer;
  logic                       div_start;
  logic                       div_done;
  logic signed [SW-1:0]       div_quot;

  assign in_accept = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign mode      = in_tuser;
  assign sample    = $signed(in_tdata[SW-1:0]);

  always_comb begin
    h           = (horizon_r == '0) ? COUNT_WIDTH'(1) : horizon_r;
    d           = {sample[SW-1], sample} - {base_avg_r[SW-1], base_avg_r};
    above       = $signed(CMP_W'(d)) > $signed(CMP_W'({1'b0, threshold_r}));
    pressed_nxt = above ? ((pressed_r == '1) ? pressed_r : pressed_r + 1'b1) : '0;
    touch       = pressed_nxt > run_limit_r;
    hold_tmp    = touch ? hold_len_r : hold_r;
    ind_tmp     = touch ? 1'b0 : ind_r;
    hold_nxt    = hold_tmp;
    ind_nxt     = ind_tmp;
    if (hold_tmp != '0) begin
      if (hold_tmp == COUNT_WIDTH'(1)) begin
        ind_nxt = 1'b1;
      end
      hold_nxt = hold_tmp - 1'b1;
    end
    if (d[SW] != d[SW-1]) begin
      sat_d = d[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sat_d = d[SW-1:0];
    end
    blink_inc = blink_r + 1'b1;
    numer     = prod_r + NUM_WIDTH'(add_r);
  end

  assign div_start = (state_r == S_ADD);

  lcd_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .numer   (numer),
    .divisor (dvs_r),
    .done    (div_done),
    .quot    (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      run_limit_r <= RUN_LIMIT_RESET;
      horizon_r   <= HORIZON_RESET;
      hold_len_r  <= HOLD_RESET;
      weight_r    <= WEIGHT_RESET;
      blink_per_r <= BLINK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRESHOLD:  threshold_r <= cfg_data[THRESHOLD_WIDTH-1:0];
        CFG_RUN_LIMIT:  run_limit_r <= cfg_data[COUNT_WIDTH-1:0];
        CFG_HORIZON:    horizon_r   <= cfg_data[COUNT_WIDTH-1:0];
        CFG_HOLD:       hold_len_r  <= cfg_data[COUNT_WIDTH-1:0];
        CFG_REF_WEIGHT: weight_r    <= cfg_data[WEIGHT_WIDTH-1:0];
        CFG_BLINK:      blink_per_r <= cfg_data[COUNT_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= K_BASE;
      prev_mode_r <= 1'b0;
      base_avg_r  <= '0;
      cal_avg_r   <= '0;
      pressed_r   <= '0;
      hold_r      <= '0;
      blink_r     <= '0;
      ind_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            prev_mode_r <= mode;
            flag_r      <= !mode && prev_mode_r;
            diff_r      <= (!mode && !prev_mode_r) ? sat_d : '0;
            scale_r     <= '0;
            if (mode && !prev_mode_r) begin
              cal_avg_r <= '0;
              state_r   <= S_OUT;
            end else if (mode) begin
              if (blink_inc > blink_per_r) begin
                ind_r   <= !ind_r;
                blink_r <= '0;
              end else begin
                blink_r <= blink_inc;
              end
              mul_a_r <= cal_avg_r;
              fac_r   <= {h, 1'b0} - 1'b1;
              add_r   <= sample;
              dvs_r   <= DIVISOR_WIDTH'({h, 1'b0});
              kind_r  <= K_CAL;
              state_r <= S_MUL;
            end else if (prev_mode_r) begin
              mul_a_r <= cal_avg_r;
              fac_r   <= FACTOR_WIDTH'(1);
              add_r   <= '0;
              dvs_r   <= weight_r;
              kind_r  <= K_SCALE;
              state_r <= (weight_r == '0) ? S_OUT : S_MUL;
            end else begin
              pressed_r <= pressed_nxt;
              hold_r    <= hold_nxt;
              ind_r     <= ind_nxt;
              mul_a_r   <= base_avg_r;
              fac_r     <= {1'b0, h} - 1'b1;
              add_r     <= sample;
              dvs_r     <= DIVISOR_WIDTH'(h);
              kind_r    <= K_BASE;
              state_r   <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r  <= NUM_WIDTH'(mul_a_r) * NUM_WIDTH'($signed({1'b0, fac_r}));
          state_r <= S_ADD;
        end
        S_ADD: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            case (kind_r)
              K_BASE:  base_avg_r <= div_quot;
              K_CAL:   cal_avg_r  <= div_quot;
              K_SCALE: scale_r    <= div_quot;
              default: begin
              end
            endcase
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_ind_r   <= ind_r;
            out_diff_r  <= diff_r;
            out_scale_r <= scale_r;
            out_flag_r  <= flag_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_scale_r, out_diff_r, out_ind_r};
  assign out_tuser  = out_flag_r;

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("Divider finished outside the divide state.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("Block stayed ready after taking a word.");

  a_scale_no_diff: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[SW:1] == '0)
    else $error("Scale word carries a nonzero difference.");

  a_no_scale_unflagged: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[2*SW:SW+1] == '0)
    else $error("Scale value present without the scale flag.");
`endif

endmodule

### tb/load_cell_touch_detector_test.sv
`timescale 1ns / 100ps
// Self-checking test of load_cell_touch_detector: a directed table, then random
// phases under several register settings, every result word checked against a predictor.
// Depends on lcd_pkg and on the detector RTL.
module load_cell_touch_detector_test;
  import lcd_pkg::*;

  localparam int SW            = SAMPLE_WIDTH;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = 100;
  localparam int LONG_STALL    = 1500;
  localparam int STALL_TRIGGER = 400;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 220;
  localparam int MAX_REPORTS   = 40;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE = CFG_INDEX_WIDTH'(CFG_BLINK) + 3'd1;
  localparam longint SAT_HI = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;
  localparam logic [SW-1:0] SAMPLE_MAX = SW'(SAT_HI);
  localparam logic [SW-1:0] SAMPLE_MIN = SW'(SAT_LO);

  typedef struct packed {
    logic          indicator;
    logic [SW-1:0] difference;
    logic [SW-1:0] scale;
    logic          scale_valid;
  } reading_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [CFG_DATA_WIDTH-1:0]  data;
    logic [SW-1:0]              sample;
    logic                       mode;
    logic                       typed;
    reading_t                   want;
  } vector_t;

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [IN_DATA_WIDTH-1:0]   in_tdata   = '0;
  logic                       in_tuser   = 1'b0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [OUT_DATA_WIDTH-1:0]  out_tdata;
  logic                       out_tuser;
  logic                       cfg_valid  = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index  = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data   = '0;

  load_cell_touch_detector u_top (.*);

  // Shadow registers and detector state.
  logic [THRESHOLD_WIDTH-1:0] thr_reg       = THRESHOLD_RESET;
  logic [COUNT_WIDTH-1:0]     run_limit_reg = RUN_LIMIT_RESET;
  logic [COUNT_WIDTH-1:0]     horizon_reg   = HORIZON_RESET;
  logic [COUNT_WIDTH-1:0]     hold_reg      = HOLD_RESET;
  logic [WEIGHT_WIDTH-1:0]    weight_reg    = WEIGHT_RESET;
  logic [COUNT_WIDTH-1:0]     blink_reg     = BLINK_RESET;

  logic                   last_mode   = 1'b0;
  longint                 baseline    = 0;
  longint                 cal_mean    = 0;
  logic [COUNT_WIDTH-1:0] run_count   = '0;
  logic [COUNT_WIDTH-1:0] hold_count  = '0;
  logic [COUNT_WIDTH-1:0] blink_count = '0;
  logic                   indicator   = 1'b1;

  reading_t pending_readings[$];

  int error_count   = 0;
  int checked_count = 0;
  int scale_count   = 0;
  int low_count     = 0;
  int sent_count    = 0;
  int burst_left    = 0;
  int cycle_count   = 0;

  always #5 clk = ~clk;

  function automatic longint div_floor(input longint n, input longint d);
    longint q;
    q = n / d;
    if (n < 0 && q * d != n) q = q - 1;
    return q;
  endfunction

  function automatic logic [SW-1:0] clip(input longint v);
    if (v > SAT_HI) v = SAT_HI;
    else if (v < SAT_LO) v = SAT_LO;
    return SW'(v);
  endfunction

  function automatic longint noise(input int unsigned amp);
    return longint'($urandom_range(0, 2 * amp)) - longint'(amp);
  endfunction

  function automatic reading_t next_reading(input logic [SW-1:0] sample, input logic mode);
    reading_t r;
    longint s, h, d;
    s = longint'(signed'(sample));
    h = (horizon_reg == '0) ? 1 : longint'(horizon_reg);
    r = '0;
    if (mode && !last_mode) begin
      cal_mean = 0;
    end else if (mode) begin
      cal_mean = div_floor(cal_mean * (2 * h - 1) + s, 2 * h);
      blink_count = blink_count + 1'b1;
      if (blink_count > blink_reg) begin
        indicator = ~indicator;
        blink_count = '0;
      end
    end else if (last_mode) begin
      if (weight_reg != '0) r.scale = SW'(div_floor(cal_mean, longint'(weight_reg)));
      r.scale_valid = 1'b1;
    end else begin
      d = s - baseline;
      if (d > longint'(thr_reg)) begin
        if (run_count != '1) run_count = run_count + 1'b1;
      end else begin
        run_count = '0;
      end
      if (run_count > run_limit_reg) begin
        indicator = 1'b0;
        hold_count = hold_reg;
      end
      if (hold_count != '0) begin
        if (hold_count == 8'd1) indicator = 1'b1;
        hold_count = hold_count - 1'b1;
      end
      r.difference = clip(d);
      baseline = div_floor(baseline * (h - 1) + s, h);
    end
    last_mode = mode;
    r.indicator = indicator;
    return r;
  endfunction

  function automatic void apply_register(input logic [CFG_INDEX_WIDTH-1:0] index,
                                         input logic [CFG_DATA_WIDTH-1:0] data);
    case (index)
      CFG_THRESHOLD:  thr_reg = data[THRESHOLD_WIDTH-1:0];
      CFG_RUN_LIMIT:  run_limit_reg = data[COUNT_WIDTH-1:0];
      CFG_HORIZON:    horizon_reg = data[COUNT_WIDTH-1:0];
      CFG_HOLD:       hold_reg = data[COUNT_WIDTH-1:0];
      CFG_REF_WEIGHT: weight_reg = data[WEIGHT_WIDTH-1:0];
      CFG_BLINK:      blink_reg = data[COUNT_WIDTH-1:0];
      default: ;
    endcase
  endfunction

  function automatic vector_t item_row(input logic [SW-1:0] sample, input logic mode);
    vector_t v;
    v = '0;
    v.kind = ROW_ITEM;
    v.sample = sample;
    v.mode = mode;
    return v;
  endfunction

  function automatic vector_t checked_row(input logic [SW-1:0] sample, input logic mode,
                                          input logic ind, input logic [SW-1:0] diff);
    vector_t v;
    v = item_row(sample, mode);
    v.typed = 1'b1;
    v.want.indicator = ind;
    v.want.difference = diff;
    return v;
  endfunction

  function automatic vector_t write_row(input logic [CFG_INDEX_WIDTH-1:0] index,
                                        input logic [CFG_DATA_WIDTH-1:0] data);
    vector_t v;
    v = '0;
    v.kind = ROW_WRITE;
    v.index = index;
    v.data = data;
    return v;
  endfunction

  // Offers one word in bursts with random gaps, then records what the block must return.
  task automatic present(input logic [SW-1:0] sample, input logic mode,
                         input logic typed = 1'b0, input reading_t want = '0);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 60) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= IN_DATA_WIDTH'(sample);
    in_tuser <= mode;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    sent_count++;
    want = typed ? want : next_reading(sample, mode);
    if (typed) void'(next_reading(sample, mode));
    pending_readings.push_back(want);
  endtask

  task automatic drain_block();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] index,
                                input logic [CFG_DATA_WIDTH-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    apply_register(index, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random_phase(input int phase);
    logic [CFG_DATA_WIDTH-1:0] noise_bits;
    int start, len, kind;
    drain_block();
    write_register(CFG_SPARE, CFG_DATA_WIDTH'($urandom));
    noise_bits = CFG_DATA_WIDTH'($urandom);
    if (phase == 0) begin
      write_register(CFG_THRESHOLD, '0);
      write_register(CFG_RUN_LIMIT, {noise_bits[23:8], 8'd0});
      write_register(CFG_HORIZON, {noise_bits[23:8], 8'd1});
      write_register(CFG_HOLD, 24'd1);
      write_register(CFG_REF_WEIGHT, {noise_bits[23:16], 16'd1});
      write_register(CFG_BLINK, 24'd0);
    end else if (phase == 1) begin
      write_register(CFG_THRESHOLD, 24'hFFFFFF);
      write_register(CFG_RUN_LIMIT, 24'd254);
      write_register(CFG_HORIZON, {noise_bits[23:8], 8'd255});
      write_register(CFG_HOLD, 24'd255);
      write_register(CFG_REF_WEIGHT, 24'h00FFFF);
      write_register(CFG_BLINK, {noise_bits[23:8], 8'd255});
    end else begin
      case ($urandom_range(0, 3))
        0: write_register(CFG_THRESHOLD, '0);
        1: write_register(CFG_THRESHOLD, 24'hFFFFFF);
        default: write_register(CFG_THRESHOLD, CFG_DATA_WIDTH'($urandom_range(0, 200000)));
      endcase
      write_register(CFG_RUN_LIMIT, {noise_bits[23:8],
        8'(($urandom_range(0, 7) == 0) ? 254 : $urandom_range(0, 6))});
      write_register(CFG_HORIZON, {noise_bits[23:8],
        8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) * 255 : $urandom_range(1, 128))});
      write_register(CFG_HOLD, {noise_bits[23:8],
        8'(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 30))});
      case ($urandom_range(0, 7))
        0: write_register(CFG_REF_WEIGHT, {noise_bits[23:16], 16'd0});
        1: write_register(CFG_REF_WEIGHT, {noise_bits[23:16], 16'hFFFF});
        default: write_register(CFG_REF_WEIGHT, {noise_bits[23:16], 16'($urandom_range(1, 5000))});
      endcase
      write_register(CFG_BLINK, {noise_bits[23:8],
        8'(($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 20))});
    end

    start = sent_count;
    while (sent_count - start < PHASE_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        len = $urandom_range(3, 30);
        repeat (len) present(clip(baseline + noise(4000)), 1'b0);
      end else if (kind <= 5) begin
        len = ($urandom_range(0, 1) == 0) ? $urandom_range(1, run_limit_reg + 1)
                                          : run_limit_reg + $urandom_range(1, 6);
        repeat (len) begin
          if ($urandom_range(0, 15) == 0)
            present(clip(baseline + longint'(thr_reg)), 1'b0);
          else
            present(clip(baseline + longint'(thr_reg) + 1 + $urandom_range(0, 3000)), 1'b0);
        end
      end else if (kind <= 7) begin
        present(SW'($urandom), 1'b1);
        len = $urandom_range(0, 25);
        repeat (len) begin
          if ($urandom_range(0, 7) == 0) present(SW'($urandom), 1'b1);
          else present(clip(noise(1 << 24)), 1'b1);
        end
        present(SW'($urandom), 1'b0);
      end else if (kind == 8) begin
        len = $urandom_range(1, 4);
        repeat (len) present(SW'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        present(($urandom_range(0, 1) == 0) ? SAMPLE_MAX : SAMPLE_MIN, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic check_field(input string what, input logic [SW-1:0] want,
                             input logic [SW-1:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t ns: %s expected %0d, got %0d", $time, what, signed'(want), signed'(got));
    end
  endtask

  always @(posedge clk) begin : check_output
    reading_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.indicator = out_tdata[0];
      got.difference = out_tdata[SW:1];
      got.scale = out_tdata[2*SW:SW+1];
      got.scale_valid = out_tuser;
      if (pending_readings.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t ns: result word with nothing expected, got %h", $time, out_tdata);
      end else begin
        want = pending_readings.pop_front();
        checked_count++;
        if (got.scale_valid) scale_count++;
        if (!got.indicator) low_count++;
        check_field("indicator_level", SW'(want.indicator), SW'(got.indicator));
        check_field("difference", want.difference, got.difference);
        check_field("scale_value", want.scale, got.scale);
        check_field("scale_valid", SW'(want.scale_valid), SW'(got.scale_valid));
      end
    end
  end

  // Receiver: stalls on its own pattern, with one long hold-off that backs up the input.
  initial begin : receiver
    int style, span;
    bit long_done;
    long_done = 1'b0;
    forever begin
      if (!long_done && checked_count >= STALL_TRIGGER) begin
        long_done = 1'b1;
        @(posedge clk);
        out_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end
      style = $urandom_range(0, 3);
      span = $urandom_range(10, 300);
      repeat (span) begin
        @(posedge clk);
        case (style)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 7) == 0);
          default: out_tready <= ~out_tready;
        endcase
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding.",
             cycle_count, pending_readings.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    vector_t table_rows[$];
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: extremes of the sample, a touch, one calibration pass.
    table_rows.push_back(checked_row('0, 1'b0, 1'b1, '0));
    table_rows.push_back(checked_row(SAMPLE_MAX, 1'b0, 1'b1, SAMPLE_MAX));
    table_rows.push_back(checked_row(SAMPLE_MIN, 1'b0, 1'b1, SAMPLE_MIN));
    repeat (5) table_rows.push_back(item_row(SAMPLE_MAX, 1'b0));
    table_rows.push_back(item_row('0, 1'b1));
    table_rows.push_back(item_row(32'h0000_1234, 1'b1));
    table_rows.push_back(item_row(SAMPLE_MIN, 1'b1));
    table_rows.push_back(item_row(-32'sd5, 1'b1));
    table_rows.push_back(item_row('0, 1'b0));
    // Zero threshold, run limit, horizon, hold, weight and blink period.
    table_rows.push_back(write_row(CFG_THRESHOLD, '0));
    table_rows.push_back(write_row(CFG_RUN_LIMIT, '0));
    table_rows.push_back(write_row(CFG_HORIZON, '0));
    table_rows.push_back(write_row(CFG_HOLD, '0));
    table_rows.push_back(write_row(CFG_REF_WEIGHT, '0));
    table_rows.push_back(write_row(CFG_BLINK, '0));
    table_rows.push_back(item_row(32'd1, 1'b0));
    table_rows.push_back(item_row(32'h100, 1'b0));
    table_rows.push_back(item_row(32'd5, 1'b1));
    table_rows.push_back(item_row(-32'sd7, 1'b1));
    table_rows.push_back(item_row(32'd9, 1'b1));
    table_rows.push_back(item_row('0, 1'b0));
    // Largest values of every register but the run limit, which is set to 254.
    table_rows.push_back(write_row(CFG_THRESHOLD, 24'hFFFFFF));
    table_rows.push_back(write_row(CFG_RUN_LIMIT, 24'd254));
    table_rows.push_back(write_row(CFG_HORIZON, 24'd255));
    table_rows.push_back(write_row(CFG_HOLD, 24'd255));
    table_rows.push_back(write_row(CFG_REF_WEIGHT, 24'h00FFFF));
    table_rows.push_back(write_row(CFG_BLINK, 24'd255));
    table_rows.push_back(item_row(SAMPLE_MAX, 1'b1));
    table_rows.push_back(item_row(SAMPLE_MAX, 1'b1));
    table_rows.push_back(item_row('0, 1'b0));
    table_rows.push_back(item_row(SAMPLE_MIN, 1'b0));
    table_rows.push_back(item_row(SAMPLE_MAX, 1'b0));

    foreach (table_rows[i]) begin
      if (table_rows[i].kind == ROW_WRITE) begin
        drain_block();
        write_register(table_rows[i].index, table_rows[i].data);
      end else begin
        present(table_rows[i].sample, table_rows[i].mode, table_rows[i].typed,
                table_rows[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) run_random_phase(phase);

    drain_block();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d readings over %0d register settings; %0d results checked.",
             sent_count, PHASES + 3, checked_count);
    $display("Seen %0d scale results and %0d low indicator results in %0d cycles.",
             scale_count, low_count, cycle_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
